### rtl/kabf_pkg.sv
// Shared types, codes and the filter step program for the angle/bias Kalman filter.
`default_nettype none
package kabf_pkg;

  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_SUB = 2'd1;
  localparam logic [OP_W-1:0] OP_MUL = 2'd2;
  localparam logic [OP_W-1:0] OP_DIV = 2'd3;

  localparam int SRC_W     = 5;
  localparam int MEM_AW    = 4;
  localparam int MEM_DEPTH = 16;

  // scratch/state memory addresses (bit 4 clear)
  localparam logic [SRC_W-1:0] A_ANG  = 5'd0;
  localparam logic [SRC_W-1:0] A_BIAS = 5'd1;
  localparam logic [SRC_W-1:0] A_P00  = 5'd2;
  localparam logic [SRC_W-1:0] A_P01  = 5'd3;
  localparam logic [SRC_W-1:0] A_P10  = 5'd4;
  localparam logic [SRC_W-1:0] A_P11  = 5'd5;
  localparam logic [SRC_W-1:0] A_T    = 5'd6;
  localparam logic [SRC_W-1:0] A_DP   = 5'd7;
  localparam logic [SRC_W-1:0] A_S    = 5'd8;
  localparam logic [SRC_W-1:0] A_K0   = 5'd9;
  localparam logic [SRC_W-1:0] A_K1   = 5'd10;
  localparam logic [SRC_W-1:0] A_Y    = 5'd11;
  localparam logic [SRC_W-1:0] A_Q00  = 5'd12;
  localparam logic [SRC_W-1:0] A_Q01  = 5'd13;
  // sample and register operands (bit 4 set)
  localparam logic [SRC_W-1:0] SRC_RATE = 5'd16;
  localparam logic [SRC_W-1:0] SRC_MEAS = 5'd17;
  localparam logic [SRC_W-1:0] SRC_DT   = 5'd18;
  localparam logic [SRC_W-1:0] SRC_QA   = 5'd19;
  localparam logic [SRC_W-1:0] SRC_QB   = 5'd20;
  localparam logic [SRC_W-1:0] SRC_R    = 5'd21;

  localparam int CFG_IW = 2;
  localparam logic [CFG_IW-1:0] CFG_QA = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_QB = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_R  = 2'd2;

  localparam int PC_W  = 5;
  localparam int NSTEP = 29;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [SRC_W-1:0] dst;
    logic [SRC_W-1:0] a;
    logic [SRC_W-1:0] b;
  } uop_t;

  typedef struct packed {
    logic load;
    logic fetch;
    logic start;
    logic emit;
    uop_t uop;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic out_full;
  } dp_sts_t;

  function automatic uop_t prog(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      5'd0:  u = '{OP_SUB, A_T,    SRC_RATE, A_BIAS};
      5'd1:  u = '{OP_MUL, A_T,    SRC_DT,   A_T};
      5'd2:  u = '{OP_ADD, A_ANG,  A_ANG,    A_T};
      5'd3:  u = '{OP_MUL, A_DP,   SRC_DT,   A_P11};
      5'd4:  u = '{OP_SUB, A_T,    A_DP,     A_P01};
      5'd5:  u = '{OP_SUB, A_T,    A_T,      A_P10};
      5'd6:  u = '{OP_ADD, A_T,    A_T,      SRC_QA};
      5'd7:  u = '{OP_MUL, A_T,    SRC_DT,   A_T};
      5'd8:  u = '{OP_ADD, A_P00,  A_P00,    A_T};
      5'd9:  u = '{OP_SUB, A_P01,  A_P01,    A_DP};
      5'd10: u = '{OP_SUB, A_P10,  A_P10,    A_DP};
      5'd11: u = '{OP_MUL, A_T,    SRC_QB,   SRC_DT};
      5'd12: u = '{OP_ADD, A_P11,  A_P11,    A_T};
      5'd13: u = '{OP_ADD, A_S,    A_P00,    SRC_R};
      5'd14: u = '{OP_DIV, A_K0,   A_P00,    A_S};
      5'd15: u = '{OP_DIV, A_K1,   A_P10,    A_S};
      5'd16: u = '{OP_SUB, A_Y,    SRC_MEAS, A_ANG};
      5'd17: u = '{OP_MUL, A_T,    A_K0,     A_Y};
      5'd18: u = '{OP_ADD, A_ANG,  A_ANG,    A_T};
      5'd19: u = '{OP_MUL, A_T,    A_K1,     A_Y};
      5'd20: u = '{OP_ADD, A_BIAS, A_BIAS,   A_T};
      5'd21: u = '{OP_MUL, A_Q00,  A_K0,     A_P00};
      5'd22: u = '{OP_MUL, A_Q01,  A_K0,     A_P01};
      5'd23: u = '{OP_MUL, A_T,    A_K1,     A_P00};
      5'd24: u = '{OP_SUB, A_P10,  A_P10,    A_T};
      5'd25: u = '{OP_MUL, A_T,    A_K1,     A_P01};
      5'd26: u = '{OP_SUB, A_P11,  A_P11,    A_T};
      5'd27: u = '{OP_SUB, A_P00,  A_P00,    A_Q00};
      5'd28: u = '{OP_SUB, A_P01,  A_P01,    A_Q01};
      default: u = '{OP_ADD, A_T, A_T, A_T};
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

### rtl/kabf_datapath.sv
// Datapath: operand memory, saturating add/sub, serial multiplier and divider, output register.
`default_nettype none
module kabf_datapath #(
  parameter int W = 32,
  parameter int F = 24
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire  [W-1:0]                  in_rate,
  input  wire  [W-1:0]                  in_meas,
  input  wire  [F:0]                    in_dt,
  input  wire                           cfg_valid,
  input  wire  [kabf_pkg::CFG_IW-1:0]   cfg_index,
  input  wire  [F:0]                    cfg_data,
  input  kabf_pkg::dp_cmd_t             cmd,
  output kabf_pkg::dp_sts_t             sts,
  input  wire                           out_tready,
  output logic                          out_tvalid,
  output logic [W-1:0]                  out_angle,
  output logic [W-1:0]                  out_bias
);
  import kabf_pkg::*;

  localparam int XW  = ((W > F + 1) ? W : F + 1) + 1;
  localparam int NIT = (W + 1) / 2;
  localparam int LB  = 2 * NIT;
  localparam int PW  = W + 2 + LB;
  localparam int DW  = W + F;
  localparam int CW  = $clog2(DW + 1);
  localparam int SW  = 2 * W + F + 2;
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] LIMN = {1'b1, {(W-1){1'b0}}};
  localparam logic [2*W:0] MHALF = (2*W+1)'(1) << (F - 1);
  localparam longint unsigned ONE = 64'd1 << F;
  localparam logic [F:0] QA_RST = (F+1)'((ONE + 64'd500) / 64'd1000);
  localparam logic [F:0] QB_RST = (F+1)'((3 * ONE + 64'd500) / 64'd1000);
  localparam logic [F:0] R_RST  = (F+1)'((3 * ONE + 64'd50) / 64'd100);

  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_ALU  = 3'd1;
  localparam logic [2:0] M_MUL  = 3'd2;
  localparam logic [2:0] M_DIV  = 3'd3;
  localparam logic [2:0] M_FIN  = 3'd4;

  function automatic logic [W-1:0] ureg(input logic [F:0] v);
    logic [XW-1:0] e;
    e = XW'(v);
    if (e > XW'(MAXV)) return MAXV;
    return e[W-1:0];
  endfunction

  function automatic logic [W-1:0] mag(input logic [W-1:0] x);
    return x[W-1] ? (~x + 1'b1) : x;
  endfunction

  function automatic logic [W-1:0] sat_signed(input logic [SW-1:0] q, input logic neg);
    logic [W-1:0] lim;
    logic [W-1:0] v;
    lim = neg ? LIMN : MAXV;
    v = (q > SW'(lim)) ? lim : q[W-1:0];
    return neg ? (~v + 1'b1) : v;
  endfunction

  logic [F:0]   qa_r, qb_r, rn_r;
  logic [W-1:0] rate_r, meas_r, dt_r;
  logic [W-1:0] mem_r [0:MEM_DEPTH-1];
  logic [MEM_DEPTH-1:0] vld_r;
  logic [W-1:0] mem_a_r, mem_b_r, sel_a_r, sel_b_r;
  logic         vld_a_r, vld_b_r, is_in_a_r, is_in_b_r;
  logic [2:0]   mode_r;
  logic [CW-1:0] cnt_r;
  logic [OP_W-1:0]  op_r;
  logic [SRC_W-1:0] dst_r;
  logic         neg_r, dzero_r;
  logic [W-1:0] ma_r, md_r;
  logic [PW-1:0] pr_r;
  logic [W:0]   rem_r;
  logic [DW-1:0] nq_r;
  logic [W-1:0] ang_r, bias_r;
  logic         out_valid_r;
  logic [W-1:0] out_angle_r, out_bias_r;

  logic [W-1:0] opa, opb, res, alu_res, mul_res, div_res;
  logic [W:0]   ext_a, ext_b, asum;
  logic [W+1:0] addv, upper;
  logic [PW-1:0] pr_nxt;
  logic [2*W:0] msum;
  logic [W:0]   rsh, rem_nxt;
  logic         ge, rbit, done;
  logic [DW:0]  dq;

  function automatic logic [W-1:0] insel(input logic [SRC_W-1:0] c);
    case (c)
      SRC_RATE: return rate_r;
      SRC_MEAS: return meas_r;
      SRC_DT:   return dt_r;
      SRC_QA:   return ureg(qa_r);
      SRC_QB:   return ureg(qb_r);
      SRC_R:    return ureg(rn_r);
      default:  return '0;
    endcase
  endfunction

  assign opa = is_in_a_r ? sel_a_r : (vld_a_r ? mem_a_r : '0);
  assign opb = is_in_b_r ? sel_b_r : (vld_b_r ? mem_b_r : '0);

  always_comb begin
    ext_a = {opa[W-1], opa};
    ext_b = {opb[W-1], opb};
    asum  = (op_r == OP_SUB) ? ext_a - ext_b : ext_a + ext_b;
    if (asum[W] != asum[W-1]) alu_res = asum[W] ? LIMN : MAXV;
    else alu_res = asum[W-1:0];
  end

  always_comb begin
    case (pr_r[1:0])
      2'd0:    addv = '0;
      2'd1:    addv = {2'b00, ma_r};
      2'd2:    addv = {1'b0, ma_r, 1'b0};
      default: addv = {2'b00, ma_r} + {1'b0, ma_r, 1'b0};
    endcase
    upper  = pr_r[PW-1:LB] + addv;
    pr_nxt = {upper, pr_r[LB-1:0]} >> 2;
    msum   = {1'b0, pr_r[2*W-1:0]} + MHALF;
    mul_res = sat_signed(SW'(msum[2*W:F]), neg_r);
  end

  always_comb begin
    rsh     = {rem_r[W-1:0], nq_r[DW-1]};
    ge      = rsh >= {1'b0, md_r};
    rem_nxt = ge ? rsh - {1'b0, md_r} : rsh;
    rbit    = {rem_r, 1'b0} >= {2'b00, md_r};
    dq      = (DW+1)'(nq_r) + (DW+1)'(rbit);
    div_res = dzero_r ? '0 : sat_signed(SW'(dq), neg_r);
  end

  assign done = (mode_r == M_ALU) || (mode_r == M_FIN);
  assign res  = (mode_r == M_ALU) ? alu_res : ((op_r == OP_MUL) ? mul_res : div_res);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qa_r        <= QA_RST;
      qb_r        <= QB_RST;
      rn_r        <= R_RST;
      vld_r       <= '0;
      mode_r      <= M_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_QA:  qa_r <= cfg_data;
          CFG_QB:  qb_r <= cfg_data;
          CFG_R:   rn_r <= cfg_data;
          default: ;
        endcase
      end
      if (done) vld_r[dst_r[MEM_AW-1:0]] <= 1'b1;
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      case (mode_r)
        M_IDLE: begin
          if (cmd.start) begin
            cnt_r <= '0;
            case (cmd.uop.op)
              OP_MUL:  mode_r <= M_MUL;
              OP_DIV:  mode_r <= (opb == '0) ? M_FIN : M_DIV;
              default: mode_r <= M_ALU;
            endcase
          end
        end
        M_MUL: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CW'(NIT - 1)) mode_r <= M_FIN;
        end
        M_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CW'(DW - 1)) mode_r <= M_FIN;
        end
        default: mode_r <= M_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rate_r <= in_rate;
      meas_r <= in_meas;
      dt_r   <= ureg(in_dt);
    end
    if (cmd.fetch) begin
      mem_a_r   <= mem_r[cmd.uop.a[MEM_AW-1:0]];
      mem_b_r   <= mem_r[cmd.uop.b[MEM_AW-1:0]];
      vld_a_r   <= vld_r[cmd.uop.a[MEM_AW-1:0]];
      vld_b_r   <= vld_r[cmd.uop.b[MEM_AW-1:0]];
      is_in_a_r <= cmd.uop.a[SRC_W-1];
      is_in_b_r <= cmd.uop.b[SRC_W-1];
      sel_a_r   <= insel(cmd.uop.a);
      sel_b_r   <= insel(cmd.uop.b);
    end
    if (cmd.start && mode_r == M_IDLE) begin
      op_r    <= cmd.uop.op;
      dst_r   <= cmd.uop.dst;
      neg_r   <= opa[W-1] ^ opb[W-1];
      ma_r    <= mag(opa);
      md_r    <= mag(opb);
      dzero_r <= (opb == '0);
      pr_r    <= {{(W+2){1'b0}}, LB'(mag(opb))};
      rem_r   <= '0;
      nq_r    <= {mag(opa), {F{1'b0}}};
    end
    if (mode_r == M_MUL) pr_r <= pr_nxt;
    if (mode_r == M_DIV) begin
      rem_r <= rem_nxt;
      nq_r  <= {nq_r[DW-2:0], ge};
    end
    if (done) begin
      mem_r[dst_r[MEM_AW-1:0]] <= res;
      if (dst_r == A_ANG) ang_r <= res;
      if (dst_r == A_BIAS) bias_r <= res;
    end
    if (cmd.emit) begin
      out_angle_r <= ang_r;
      out_bias_r  <= bias_r;
    end
  end

  assign sts.done     = done;
  assign sts.out_full = out_valid_r;
  assign out_tvalid   = out_valid_r;
  assign out_angle    = out_angle_r;
  assign out_bias     = out_bias_r;

endmodule
`default_nettype wire

### rtl/kabf_ctrl.sv
// Controller: accepts a sample, steps the filter program through the datapath, emits the result.
`default_nettype none
module kabf_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  input  kabf_pkg::dp_sts_t   sts,
  output kabf_pkg::dp_cmd_t   cmd
);
  import kabf_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]      state_r, state_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    cmd       = '0;
    cmd.uop   = prog(pc_r);
    in_tready = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          pc_nxt    = '0;
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (sts.done) begin
          if (pc_r == PC_W'(NSTEP - 1)) begin
            state_nxt = S_EMIT;
          end else begin
            pc_nxt    = pc_r + 1'b1;
            state_nxt = S_FETCH;
          end
        end
      end
      S_EMIT: begin
        if (!sts.out_full) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/kalman_angle_bias_filter.sv
// Top level of the two-state angle/gyro-bias Kalman filter.
// One sample transaction (rate, measured angle, time step) yields one result transaction
// (filtered angle, estimated bias), in fixed point with FRAC_BITS fraction bits, signed but for
// the unsigned time step, saturated to the word range. Samples are processed one at a time:
// a 29-step program runs on one shared datapath with a 2-bit serial multiplier and a 1-bit
// restoring divider (a zero divisor skips the serial division). The program holds 17
// add/subtracts, 10 multiplies and 2 divides.
// A new sample is taken while the previous result still waits on the output.
// Configuration writes are accepted every cycle and must only occur while idle.
`default_nettype none
module kalman_angle_bias_filter #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 24
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // gyro_rate, measured_angle, time_step (lowest bits first)
  input  wire  [((2*WORD_BITS+FRAC_BITS+1+7)/8)*8-1:0] in_tdata,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  // filtered_angle, estimated_bias (lowest bits first)
  output logic [((2*WORD_BITS+7)/8)*8-1:0]  out_tdata,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [kabf_pkg::CFG_IW-1:0]       cfg_index,
  input  wire  [FRAC_BITS:0]                cfg_data
);
  import kabf_pkg::*;

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int ODW = ((2*W+7)/8)*8;

  dp_cmd_t      cmd;
  dp_sts_t      sts;
  logic [W-1:0] out_angle, out_bias;

  assign cfg_ready = 1'b1;

  kabf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  kabf_datapath #(.W(W), .F(F)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_rate    (in_tdata[W-1:0]),
    .in_meas    (in_tdata[2*W-1:W]),
    .in_dt      (in_tdata[2*W+F:2*W]),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_angle  (out_angle),
    .out_bias   (out_bias)
  );

  assign out_tdata = ODW'({out_bias, out_angle});

  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("sample accepted but controller stayed idle");

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |-> !in_tready)
    else $error("datapath finished an operation while idle");

  a_start_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> !cmd.start)
    else $error("back-to-back operation starts");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !out_tvalid)
    else $error("result emitted over a pending transaction");

endmodule
`default_nettype wire

### test/kalman_angle_bias_filter_tb.sv
// Testbench for the angle/gyro-bias Kalman filter: random and directed samples checked against a fixed-point predictor.
`timescale 1ns / 100ps
module kalman_angle_bias_filter_tb;
  import kabf_pkg::*;

  localparam int W = 32;
  localparam int F = 24;
  localparam int IN_W = ((2*W+F+1+7)/8)*8;
  localparam int OUT_W = ((2*W+7)/8)*8;
  localparam int WATCHDOG = 20000;
  localparam longint MAXV = 64'sd2147483647;
  localparam longint MINV = -64'sd2147483648;

  typedef struct packed {
    logic [F:0]   dt;
    logic [W-1:0] meas;
    logic [W-1:0] rate;
  } sample_t;

  typedef struct packed {
    logic [W-1:0] bias;
    logic [W-1:0] angle;
  } estimate_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IW-1:0] cfg_index;
  logic [F:0] cfg_data;

  kalman_angle_bias_filter u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // filter state of the predictor
  longint ang, bias, p00, p01, p10, p11;
  longint qa, qb, rn;

  sample_t   pending_samples[$];
  estimate_t expected_estimates[$];
  int errors = 0;
  int accepted = 0;
  int produced = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic longint sat(longint x);
    return x > MAXV ? MAXV : (x < MINV ? MINV : x);
  endfunction

  function automatic longint sat_mag(bit neg, logic [127:0] m);
    longint lim;
    lim = neg ? 64'sd2147483648 : MAXV;
    if (m > lim) return neg ? -lim : lim;
    return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  function automatic longint qmul(longint a, longint b);
    logic [127:0] p;
    logic [63:0] ma, mb;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    p = {64'd0, ma} * {64'd0, mb};
    p = (p + (128'd1 << (F-1))) >> F;
    return sat_mag((a < 0) != (b < 0), p);
  endfunction

  function automatic longint qdiv(longint a, longint d);
    logic [127:0] n, q, r, md;
    logic [63:0] ma, mdv;
    if (d == 0) return 0;
    ma = a < 0 ? -a : a;
    mdv = d < 0 ? -d : d;
    md = {64'd0, mdv};
    n = {64'd0, ma} << F;
    q = n / md;
    r = n % md;
    if (r >= md - r) q = q + 1;
    return sat_mag((a < 0) != (d < 0), q);
  endfunction

  function automatic estimate_t filter_step(sample_t s);
    longint rate, meas, dt, dp, t, sv, k0, k1, y, a00, a01;
    estimate_t e;
    rate = longint'($signed(s.rate));
    meas = longint'($signed(s.meas));
    dt = longint'(s.dt);
    ang = sat(ang + qmul(dt, sat(rate - bias)));
    dp = qmul(dt, p11);
    t = sat(sat(sat(dp - p01) - p10) + qa);
    p00 = sat(p00 + qmul(dt, t));
    p01 = sat(p01 - dp);
    p10 = sat(p10 - dp);
    p11 = sat(p11 + qmul(qb, dt));
    sv = sat(p00 + rn);
    k0 = qdiv(p00, sv);
    k1 = qdiv(p10, sv);
    y = sat(meas - ang);
    ang = sat(ang + qmul(k0, y));
    bias = sat(bias + qmul(k1, y));
    a00 = p00;
    a01 = p01;
    p00 = sat(p00 - qmul(k0, a00));
    p01 = sat(p01 - qmul(k0, a01));
    p10 = sat(p10 - qmul(k1, a00));
    p11 = sat(p11 - qmul(k1, a01));
    e.angle = ang[W-1:0];
    e.bias = bias[W-1:0];
    return e;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sample driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        expected_estimates.push_back(filter_step(sample_t'(in_tdata[2*W+F:0])));
        accepted++;
      end
      if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata <= IN_W'(pending_samples.pop_front());
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_estimates.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_tdata);
          errors++;
        end else begin
          estimate_t e;
          estimate_t got;
          e = expected_estimates.pop_front();
          got = estimate_t'(out_tdata[2*W-1:0]);
          if (got.angle !== e.angle) begin
            $display("%0t: filtered_angle expected %h actual %h", $time, e.angle, got.angle);
            errors++;
          end
          if (got.bias !== e.bias) begin
            $display("%0t: estimated_bias expected %h actual %h", $time, e.bias, got.bias);
            errors++;
          end
        end
        produced++;
      end
      out_tready <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [F:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_QA) qa = longint'(value);
    else if (idx == CFG_QB) qb = longint'(value);
    else if (idx == CFG_R) rn = longint'(value);
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_samples.size() > 0 || in_tvalid || expected_estimates.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [W-1:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom();
      default: return W'($signed($urandom_range(32'h03000000)) - 32'sh01800000);
    endcase
  endfunction

  function automatic logic [F:0] rand_dt();
    case ($urandom_range(9))
      0: return 25'h1ffffff;
      1: return 25'h1000000;
      2: return '0;
      3: return 25'($urandom());
      default: return 25'($urandom_range(25'h0060000, 25'h0010000));
    endcase
  endfunction

  task automatic queue_sample(logic [W-1:0] r, logic [W-1:0] m, logic [F:0] d);
    sample_t s;
    s.rate = r;
    s.meas = m;
    s.dt = d;
    pending_samples.push_back(s);
  endtask

  task automatic queue_random(int n);
    logic [W-1:0] base;
    base = W'($signed($urandom_range(32'h02000000)) - 32'sh01000000);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 7)
        queue_sample(W'($signed($urandom_range(32'h00400000)) - 32'sh00200000),
                     base + W'($signed($urandom_range(32'h00100000)) - 32'sh00080000),
                     25'($urandom_range(25'h0060000, 25'h0020000)));
      else
        queue_sample(rand_word(), rand_word(), rand_dt());
    end
  endtask

  initial begin
    ang = 0; bias = 0; p00 = 0; p01 = 0; p10 = 0; p11 = 0;
    qa = 16777; qb = 50332; rn = 503316;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero time step and zero variance first: no correction; then extreme rates, angles and time steps
    queue_sample('0, '0, '0);
    queue_sample(32'h01000000, 32'h00800000, '0);
    queue_sample(32'h7fffffff, 32'h7fffffff, 25'h1ffffff);
    queue_sample(32'h80000000, 32'h80000000, 25'h1ffffff);
    queue_sample(32'h7fffffff, 32'h80000000, 25'h1000000);
    queue_sample(32'h80000000, 32'h7fffffff, 25'h1000000);
    queue_sample(32'hffffffff, 32'h00000001, 25'h0000001);
    queue_sample(32'h55555555, 32'haaaaaaaa, 25'h0aaaaaa);
    queue_sample(32'haaaaaaaa, 32'h55555555, 25'h1555555);
    queue_sample(32'h00100000, 32'h00200000, 25'h0028f5c);
    drain();

    // zero process noise and extreme measurement noise
    write_reg(CFG_QA, '0);
    write_reg(CFG_QB, '0);
    write_reg(CFG_R, 25'h1000000);
    queue_sample(32'h01000000, 32'h00400000, 25'h0028f5c);
    queue_sample(32'hff000000, 32'hffc00000, 25'h1000000);
    queue_random(8);
    drain();

    write_reg(CFG_QA, 25'h1000000);
    write_reg(CFG_QB, 25'h1000000);
    write_reg(CFG_R, 25'd1);
    queue_sample(32'h7fffffff, 32'h80000000, 25'h1ffffff);
    queue_random(5);
    drain();
    write_reg(CFG_QA, 25'd16777);
    write_reg(CFG_QB, 25'd50332);
    write_reg(CFG_R, 25'd503316);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 58 : 21) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 58 : 21) : 0;
      write_reg(CFG_QA, 25'($urandom_range(25'h0080000)));
      write_reg(CFG_QB, 25'($urandom_range(25'h0080000)));
      write_reg(CFG_R, 25'($urandom_range(25'h0400000, 25'd1)));
      queue_random(155);
      drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;

    $display("Ran %0d samples through directed extremes and four handshake phases,", accepted);
    $display("with noise settings from zero to one; %0d estimates checked.", produced);
    if (errors == 0 && expected_estimates.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/kabf_pkg.sv
rtl/kabf_datapath.sv
rtl/kabf_ctrl.sv
rtl/kalman_angle_bias_filter.sv
test/kalman_angle_bias_filter_tb.sv
